[rtl/sm3_pkg.sv]
`default_nettype none
package sm3_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = $clog2(QDepth);

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [31:0] SM3_IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef struct packed {
    logic [31:0] word;
    logic        blk_end;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] tmp;
    tmp = {x, x} << n;
    return tmp[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

[rtl/sm3_front.sv]
`default_nettype none
module sm3_front
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_last,
  input  wire q_status_t   q_stat,
  output logic             q_push,
  output q_entry_t         q_wdata
);

  typedef enum logic [4:0] {
    F_TAKE  = 5'b00001,
    F_PAD   = 5'b00010,
    F_ZERO  = 5'b00100,
    F_LENHI = 5'b01000,
    F_LENLO = 5'b10000
  } f_state_t;

  f_state_t    state_r, state_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] bl_r, bl_nxt;
  logic [2:0]  nb;
  logic [31:0] part_word;

  always_comb begin
    nb = (!in_last || in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
    case (nb)
      3'd0:    part_word = PAD_WORD;
      3'd1:    part_word = {in_data_word[31:24], PAD_BYTE, 16'h0};
      3'd2:    part_word = {in_data_word[31:16], PAD_BYTE, 8'h0};
      3'd3:    part_word = {in_data_word[31:8], PAD_BYTE};
      default: part_word = in_data_word;
    endcase
  end

  assign in_stall = (state_r != F_TAKE) || q_stat.full;

  always_comb begin
    state_nxt = state_r;
    bl_nxt    = bl_r;
    q_push    = 1'b0;
    q_wdata   = '{word: 32'h0, blk_end: 1'b0};
    unique case (state_r)
      F_TAKE: begin
        if (in_valid && !q_stat.full) begin
          bl_nxt = bl_r + {58'h0, nb, 3'b000};
          q_push = 1'b1;
          q_wdata.word = part_word;
          if (in_last) begin
            state_nxt = (nb == 3'd4) ? F_PAD : F_ZERO;
          end
        end
      end
      F_PAD: begin
        if (!q_stat.full) begin
          q_push = 1'b1;
          q_wdata.word = PAD_WORD;
          state_nxt = F_ZERO;
        end
      end
      F_ZERO: begin
        if (pos_r == 4'd14) begin
          state_nxt = F_LENHI;
        end else if (!q_stat.full) begin
          q_push = 1'b1;
        end
      end
      F_LENHI: begin
        if (!q_stat.full) begin
          q_push = 1'b1;
          q_wdata.word = bl_r[63:32];
          state_nxt = F_LENLO;
        end
      end
      F_LENLO: begin
        if (!q_stat.full) begin
          q_push = 1'b1;
          q_wdata.word = bl_r[31:0];
          q_wdata.blk_end = 1'b1;
          bl_nxt = 64'h0;
          state_nxt = F_TAKE;
        end
      end
      default: state_nxt = F_TAKE;
    endcase
    pos_nxt = pos_r + {3'b000, q_push};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_TAKE;
      pos_r   <= 4'd0;
      bl_r    <= 64'h0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      bl_r    <= bl_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/sm3_fifo.sv]
`default_nettype none
module sm3_fifo
  import sm3_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t wdata,
  input  wire logic     pop,
  output q_entry_t      rdata,
  output q_status_t     stat
);

  q_entry_t            mem_r [QDepth];
  logic [QAddrW-1:0]   wp_r, rp_r;
  logic [QAddrW:0]     cnt_r;

  assign stat.full  = (cnt_r == (QAddrW+1)'(QDepth));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{QAddrW{1'b0}}, push} - {{QAddrW{1'b0}}, pop};
    end
  end

endmodule
`default_nettype wire

[rtl/sm3_back.sv]
`default_nettype none
module sm3_back
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire q_status_t   q_stat,
  input  wire q_entry_t    q_rdata,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_digest_last
);

  typedef enum logic [3:0] {
    B_LOAD  = 4'b0001,
    B_ROUND = 4'b0010,
    B_FIN   = 4'b0100,
    B_OUT   = 4'b1000
  } b_state_t;

  b_state_t    state_r;
  logic [31:0] w_r  [BlkWords];
  logic [31:0] r_r  [8];
  logic [31:0] cv_r [8];
  logic [3:0]  cnt_r;
  logic [5:0]  j_r;
  logic [2:0]  oidx_r;
  logic        end_r;

  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, wn;

  always_comb begin
    tj  = (j_r[5:4] == 2'b00) ? T_LOW : T_HIGH;
    a12 = rotl(r_r[0], 5'd12);
    ss1 = rotl(a12 + r_r[4] + rotl(tj, j_r[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j_r[5:4] == 2'b00) begin
      ff = r_r[0] ^ r_r[1] ^ r_r[2];
      gg = r_r[4] ^ r_r[5] ^ r_r[6];
    end else begin
      ff = (r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]);
      gg = (r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]);
    end
    tt1 = ff + r_r[3] + ss2 + (w_r[0] ^ w_r[4]);
    tt2 = gg + r_r[7] + ss1 + w_r[0];
    wn  = perm1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15))
          ^ rotl(w_r[3], 5'd7) ^ w_r[10];
  end

  assign q_pop           = (state_r == B_LOAD) && !q_stat.empty;
  assign out_valid       = (state_r == B_OUT);
  assign out_digest_word = cv_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_digest_last = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (q_pop || state_r == B_ROUND) begin
      for (int i = 0; i < BlkWords - 1; i++) w_r[i] <= w_r[i+1];
      w_r[BlkWords-1] <= q_pop ? q_rdata.word : wn;
    end
    if (q_pop && cnt_r == 4'd15) begin
      for (int k = 0; k < 8; k++) r_r[k] <= cv_r[k];
      end_r <= q_rdata.blk_end;
    end else if (state_r == B_ROUND) begin
      r_r[3] <= r_r[2];
      r_r[2] <= rotl(r_r[1], 5'd9);
      r_r[1] <= r_r[0];
      r_r[0] <= tt1;
      r_r[7] <= r_r[6];
      r_r[6] <= rotl(r_r[5], 5'd19);
      r_r[5] <= r_r[4];
      r_r[4] <= perm0(tt2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_LOAD;
      cnt_r   <= 4'd0;
      j_r     <= 6'd0;
      oidx_r  <= 3'd0;
      for (int k = 0; k < 8; k++) cv_r[k] <= SM3_IV[k];
    end else begin
      unique case (state_r)
        B_LOAD: begin
          if (q_pop) begin
            cnt_r <= cnt_r + 4'd1;
            if (cnt_r == 4'd15) begin
              j_r     <= 6'd0;
              state_r <= B_ROUND;
            end
          end
        end
        B_ROUND: begin
          j_r <= j_r + 6'd1;
          if (j_r == 6'd63) state_r <= B_FIN;
        end
        B_FIN: begin
          for (int k = 0; k < 8; k++) cv_r[k] <= cv_r[k] ^ r_r[k];
          oidx_r  <= 3'd0;
          state_r <= end_r ? B_OUT : B_LOAD;
        end
        B_OUT: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int k = 0; k < 8; k++) cv_r[k] <= SM3_IV[k];
              state_r <= B_LOAD;
            end
          end
        end
        default: state_r <= B_LOAD;
      endcase
    end
  end

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ROUND && j_r == 6'd63) |=> (state_r == B_FIN))
    else $error("round count overrun");

  a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == B_LOAD && !out_valid))
    else $error("pop outside load phase");

  a_iv_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && oidx_r == 3'd7) |=> (cv_r[0] == SM3_IV[0] && !out_valid))
    else $error("chaining value not restored");

endmodule
`default_nettype wire

[rtl/sm3_hash_engine_core.sv]
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_stall    data_word[32] byte_count[3] last[1]
// out_     output     out_valid/out_stall  digest_word[32] word_index[3] digest_last[1]
//
// A block of 16 words is gathered from the queue and then run through 64 rounds,
// one round a cycle in the compression unit, before the result is folded into the
// chaining value; no words are taken from the queue meanwhile. Padding adds 2 to 18 words.
// The digest leaves at one word a cycle while out_stall is low.
// Reset is synchronous active low and restores the IV; no clearing pass.
`default_nettype none
module sm3_hash_engine_core
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_digest_last
);

  q_status_t q_stat;
  q_entry_t  q_wdata, q_rdata;
  logic      q_push, q_pop;

  sm3_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_word, .in_byte_count, .in_last,
    .q_stat, .q_push, .q_wdata
  );

  sm3_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .stat(q_stat)
  );

  sm3_back u_back (
    .clk, .rst_n, .q_stat, .q_rdata, .q_pop,
    .out_valid, .out_stall, .out_digest_word, .out_word_index, .out_digest_last
  );

endmodule
`default_nettype wire
